// File: sv/pes_header_parser_assert.svh
// assertion macros for the pes header parser rtl
// no dependencies; included by files that carry concurrent checks
`ifndef PES_HEADER_PARSER_ASSERT_SVH
`define PES_HEADER_PARSER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define PES_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pes header parser check failed");

// next-cycle implication, disabled in reset
`define PES_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pes header parser check failed");

`endif

// File: sv/pes_hdr_pkg.sv
// types, constants and helper functions for the pes header parser
// no dependencies; imported by every rtl module of the block
`default_nettype none

package pes_hdr_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       packet_start;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  sid_byte;
      logic [15:0] packet_length;
      logic [8:0]  header_length;
      logic [5:0]  byte6_flags;
      logic [7:0]  byte7_flags;
      logic [7:0]  header_data_length;
      logic        has_pts;
      logic [32:0] pts_value;
      logic        has_dts;
      logic [32:0] dts_value;
   } rsp_type;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_BAD_START = 3'd1,
      STATUS_BAD_FIXED = 3'd2,
      STATUS_FORBIDDEN = 3'd3,
      STATUS_SHORT     = 3'd4,
      STATUS_BAD_TS    = 3'd5
   } status_type;

   localparam logic [4:0] POS_START_LAST = 5'd2;
   localparam logic [4:0] POS_STREAM_ID  = 5'd3;
   localparam logic [4:0] POS_LEN_HI     = 5'd4;
   localparam logic [4:0] POS_LEN_LO     = 5'd5;
   localparam logic [4:0] POS_FLAGS6     = 5'd6;
   localparam logic [4:0] POS_FLAGS7     = 5'd7;
   localparam logic [4:0] POS_DATA_LEN   = 5'd8;
   localparam logic [4:0] POS_PTS_FIRST  = 5'd9;
   localparam logic [4:0] POS_PTS_LAST   = 5'd13;
   localparam logic [4:0] POS_DTS_FIRST  = 5'd14;
   localparam logic [4:0] POS_DTS_LAST   = 5'd18;

   localparam logic [23:0] START_CODE     = 24'h000001;
   localparam logic [1:0]  FIXED_BITS     = 2'b10;
   localparam logic [1:0]  PD_FORBIDDEN   = 2'b01;
   localparam logic [1:0]  PD_PTS_ONLY    = 2'b10;
   localparam logic [1:0]  PD_PTS_DTS     = 2'b11;
   localparam logic [1:0]  PD_NONE        = 2'b00;
   localparam logic [3:0]  PREFIX_PTS     = 4'b0010;
   localparam logic [3:0]  PREFIX_PTS_DTS = 4'b0011;
   localparam logic [3:0]  PREFIX_DTS     = 4'b0001;
   localparam logic [7:0]  MIN_DL_PTS     = 8'd5;
   localparam logic [7:0]  MIN_DL_PTS_DTS = 8'd10;
   localparam logic [8:0]  HDR_LEN_BASE   = 9'd6;
   localparam logic [8:0]  HDR_LEN_OPT    = 9'd9;

   localparam logic [2:0] TS_IDX_0 = 3'd0;
   localparam logic [2:0] TS_IDX_1 = 3'd1;
   localparam logic [2:0] TS_IDX_2 = 3'd2;
   localparam logic [2:0] TS_IDX_3 = 3'd3;

   function automatic logic has_optional_header(input logic [7:0] sid);
      logic res;
      case (sid)
         8'hBC, 8'hBE, 8'hBF, 8'hF0, 8'hF1, 8'hF2, 8'hF8, 8'hFF: res = 1'b0;
         default: res = 1'b1;
      endcase
      return res;
   endfunction

   function automatic logic ts_byte_ok(input logic [2:0] idx, input logic [7:0] b,
                                       input logic [3:0] prefix);
      logic res;
      case (idx)
         TS_IDX_0: res = (b[7:4] == prefix) && b[0];
         TS_IDX_1, TS_IDX_3: res = 1'b1;
         default: res = b[0];
      endcase
      return res;
   endfunction

   function automatic logic [32:0] ts_merge(input logic [32:0] acc, input logic [2:0] idx,
                                            input logic [7:0] b);
      logic [32:0] res;
      res = acc;
      case (idx)
         TS_IDX_0: res[32:30] = acc[32:30] | b[3:1];
         TS_IDX_1: res[29:22] = acc[29:22] | b;
         TS_IDX_2: res[21:15] = acc[21:15] | b[7:1];
         TS_IDX_3: res[14:7]  = acc[14:7] | b;
         default:  res[6:0]   = acc[6:0] | b[7:1];
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

// File: sv/pes_header_parser.sv
// pes packet header parser top level
// depends on pes_hdr_pkg, pes_hdr_core and pes_hdr_outreg
//
// usage:
//   req_ channel carries one packet byte per beat plus a start flag that marks
//   the first byte of a packet; the flag restarts parsing at any point
//   rsp_ channel carries one result per packet: the decoded header when it is
//   complete, or the status of the first check that fails
//   bytes after a result are dropped until the next start flag
// result timing: a result appears on rsp_valid in the cycle after the beat that
//   completes or breaks the header
// throughput: one byte per cycle unless stalled; the field-update logic sits
//   between the parser state and the result register
// stall: while a result waits and rsp_ready is low, req_ready is low; when
//   rsp_ready is high a new byte is taken in the same cycle the result leaves
// reset: synchronous; clears the result valid flag and leaves the parser
//   waiting for a start flag
`default_nettype none

module pes_header_parser (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire pes_hdr_pkg::req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output pes_hdr_pkg::rsp_type      rsp_data
);
   import pes_hdr_pkg::*;

   logic    beat_accept;
   logic    emit;
   rsp_type result;
   logic    can_take;

   assign req_ready   = can_take;
   assign beat_accept = req_valid && can_take;

   pes_hdr_core u_core (
      .clock       (clock),
      .reset       (reset),
      .beat_accept (beat_accept),
      .beat        (req_data),
      .emit        (emit),
      .result      (result)
   );

   pes_hdr_outreg u_outreg (
      .clock     (clock),
      .reset     (reset),
      .emit      (emit),
      .result    (result),
      .can_take  (can_take),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// File: sv/pes_hdr_core.sv
// per-beat header field capture, checks and result build
// depends on pes_hdr_pkg and pes_header_parser_assert.svh
`default_nettype none
`include "pes_header_parser_assert.svh"

module pes_hdr_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                beat_accept,
   input  wire pes_hdr_pkg::req_type beat,
   output logic                     emit,
   output pes_hdr_pkg::rsp_type     result
);
   import pes_hdr_pkg::*;

   logic [4:0]  pos_ff, pos_in;
   logic        fin_ff, fin_in;
   logic [15:0] sc_ff, sc_in;
   logic [7:0]  id_ff, id_in;
   logic [15:0] len_ff, len_in;
   logic [13:0] flags_ff, flags_in;
   logic [7:0]  dl_ff, dl_in;
   logic [32:0] pts_ff, pts_in;
   logic [32:0] dts_ff, dts_in;

   logic [4:0]  base_pos;
   logic [15:0] base_sc;
   logic [7:0]  base_id;
   logic [15:0] base_len;
   logic [13:0] base_flags;
   logic [7:0]  base_dl;
   logic [32:0] base_pts, base_dts;
   logic        live;
   logic [1:0]  pd;
   logic [7:0]  b;
   logic [2:0]  pts_idx, dts_idx;
   status_type  status;
   logic        got_hdr, pts_ok, dts_ok;
   logic        idle_mid_beat, at_dts_last;

   always_comb begin
      b          = beat.in_byte;
      live       = beat_accept && (beat.packet_start || !fin_ff);
      base_pos   = beat.packet_start ? '0 : pos_ff;
      base_sc    = beat.packet_start ? '0 : sc_ff;
      base_id    = beat.packet_start ? '0 : id_ff;
      base_len   = beat.packet_start ? '0 : len_ff;
      base_flags = beat.packet_start ? '0 : flags_ff;
      base_dl    = beat.packet_start ? '0 : dl_ff;
      base_pts   = beat.packet_start ? '0 : pts_ff;
      base_dts   = beat.packet_start ? '0 : dts_ff;
      pd         = base_flags[13:12];
      pts_idx    = 3'(base_pos - POS_PTS_FIRST);
      dts_idx    = 3'(base_pos - POS_DTS_FIRST);

      pos_in   = pos_ff;
      fin_in   = fin_ff;
      sc_in    = sc_ff;
      id_in    = id_ff;
      len_in   = len_ff;
      flags_in = flags_ff;
      dl_in    = dl_ff;
      pts_in   = pts_ff;
      dts_in   = dts_ff;
      emit     = 1'b0;
      status   = STATUS_OK;
      got_hdr  = 1'b0;
      pts_ok   = 1'b0;
      dts_ok   = 1'b0;

      if (live) begin
         pos_in   = base_pos + 5'd1;
         fin_in   = 1'b0;
         sc_in    = base_sc;
         id_in    = base_id;
         len_in   = base_len;
         flags_in = base_flags;
         dl_in    = base_dl;
         pts_in   = base_pts;
         dts_in   = base_dts;
         case (base_pos)
            POS_STREAM_ID: begin
               id_in = b;
            end
            POS_LEN_HI: begin
               len_in = {b, 8'd0};
            end
            POS_LEN_LO: begin
               len_in = {base_len[15:8], b};
               if (!has_optional_header(base_id)) begin
                  emit = 1'b1;
               end
            end
            POS_FLAGS6: begin
               if (b[7:6] != FIXED_BITS) begin
                  emit   = 1'b1;
                  status = STATUS_BAD_FIXED;
               end else begin
                  flags_in = {base_flags[13:6], b[5:0]};
               end
            end
            POS_FLAGS7: begin
               flags_in = {b, base_flags[5:0]};
            end
            POS_DATA_LEN: begin
               dl_in   = b;
               got_hdr = 1'b1;
               if (pd == PD_FORBIDDEN) begin
                  emit   = 1'b1;
                  status = STATUS_FORBIDDEN;
               end else if ((pd == PD_PTS_ONLY && b < MIN_DL_PTS) ||
                            (pd == PD_PTS_DTS && b < MIN_DL_PTS_DTS)) begin
                  emit   = 1'b1;
                  status = STATUS_SHORT;
               end else if (pd == PD_NONE) begin
                  emit = 1'b1;
               end
            end
            default: begin
               if (base_pos <= POS_START_LAST) begin
                  sc_in = {base_sc[7:0], b};
                  if (base_pos == POS_START_LAST && {base_sc, b} != START_CODE) begin
                     emit   = 1'b1;
                     status = STATUS_BAD_START;
                  end
               end else if (base_pos inside {[POS_PTS_FIRST:POS_PTS_LAST]}) begin
                  got_hdr = 1'b1;
                  if (!ts_byte_ok(pts_idx, b,
                                  (pd == PD_PTS_DTS) ? PREFIX_PTS_DTS : PREFIX_PTS)) begin
                     emit   = 1'b1;
                     status = STATUS_BAD_TS;
                  end else begin
                     pts_in = ts_merge(base_pts, pts_idx, b);
                     if (base_pos == POS_PTS_LAST && pd == PD_PTS_ONLY) begin
                        emit   = 1'b1;
                        pts_ok = 1'b1;
                     end
                  end
               end else if (base_pos inside {[POS_DTS_FIRST:POS_DTS_LAST]}) begin
                  got_hdr = 1'b1;
                  pts_ok  = 1'b1;
                  if (!ts_byte_ok(dts_idx, b, PREFIX_DTS)) begin
                     emit   = 1'b1;
                     status = STATUS_BAD_TS;
                  end else begin
                     dts_in = ts_merge(base_dts, dts_idx, b);
                     if (base_pos == POS_DTS_LAST) begin
                        emit   = 1'b1;
                        dts_ok = 1'b1;
                     end
                  end
               end else begin
                  fin_in = 1'b1;
               end
            end
         endcase
         if (emit) begin
            fin_in = 1'b1;
         end
      end
   end

   always_comb begin
      result.status             = status;
      result.sid_byte           = id_in;
      result.packet_length      = len_in;
      result.header_length      = got_hdr ? HDR_LEN_OPT + {1'b0, dl_in} : HDR_LEN_BASE;
      result.byte6_flags        = flags_in[5:0];
      result.byte7_flags        = flags_in[13:6];
      result.header_data_length = dl_in;
      result.has_pts            = pts_ok;
      result.pts_value          = pts_ok ? pts_in : '0;
      result.has_dts            = dts_ok;
      result.dts_value          = dts_ok ? dts_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         fin_ff   <= 1'b1;
         sc_ff    <= '0;
         id_ff    <= '0;
         len_ff   <= '0;
         flags_ff <= '0;
         dl_ff    <= '0;
         pts_ff   <= '0;
         dts_ff   <= '0;
      end else begin
         pos_ff   <= pos_in;
         fin_ff   <= fin_in;
         sc_ff    <= sc_in;
         id_ff    <= id_in;
         len_ff   <= len_in;
         flags_ff <= flags_in;
         dl_ff    <= dl_in;
         pts_ff   <= pts_in;
         dts_ff   <= dts_in;
      end
   end

   always_comb begin
      idle_mid_beat = beat_accept && !beat.packet_start && fin_ff;
      at_dts_last   = (pos_ff == POS_DTS_LAST) && !beat.packet_start;
   end

   // a result always closes the packet
   `PES_ASSERT_NEXT(a_emit_closes, clock, reset, emit, fin_ff)
   // idle parser stays silent on mid-packet beats
   `PES_ASSERT_NOW(a_idle_silent, clock, reset, idle_mid_beat, !emit)
   // a decoded dts only appears on the last timestamp beat
   `PES_ASSERT_NOW(a_dts_last, clock, reset, emit && result.has_dts, at_dts_last)

endmodule

`default_nettype wire

// File: sv/pes_hdr_outreg.sv
// result register with valid/ready handshake toward the receiver
// depends on pes_hdr_pkg
`default_nettype none

module pes_hdr_outreg (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 emit,
   input  wire pes_hdr_pkg::rsp_type result,
   output logic                      can_take,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output pes_hdr_pkg::rsp_type      rsp_data
);
   import pes_hdr_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   always_comb begin
      can_take = !valid_ff || rsp_ready;
      valid_in = valid_ff;
      data_in  = data_ff;
      if (can_take) begin
         valid_in = emit;
         if (emit) begin
            data_in = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// testbench for pes_header_parser: directed and random pes byte streams, each beat predicted
// depends on pes_hdr_pkg and the pes_header_parser rtl; needs no files or arguments
`timescale 1ns / 100ps

module tb_top;
   import pes_hdr_pkg::*;

   typedef struct {
      req_type beat;
      bit      drain_first;
   } pending_beat_type;

   typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLOCK} rx_mode_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   pending_beat_type tx_beats[$];
   rsp_type     expected_headers[$];
   logic [7:0]  packet_bytes[$];
   logic [7:0]  plain_ids[8] = '{8'hBC, 8'hBE, 8'hBF, 8'hF0, 8'hF1, 8'hF2, 8'hF8, 8'hFF};
   int          error_count = 0;
   int          header_beats = 0;
   bit          req_took = 1'b0;
   int          gap_left = 0;
   int          burst_left = 1;
   int          rx_phase = 0;
   rx_mode_type rx_mode = RX_OPEN;
   rsp_type     predicted;
   rsp_type     wanted;

   // parser state as the predictor sees it
   logic [4:0]  hp_pos = '0;
   bit          hp_done = 1'b1;
   logic [23:0] hp_start = '0;
   logic [7:0]  hp_sid = '0;
   logic [15:0] hp_len = '0;
   logic [5:0]  hp_f6 = '0;
   logic [7:0]  hp_f7 = '0;
   logic [7:0]  hp_dlen = '0;
   logic [32:0] hp_pts = '0;
   logic [32:0] hp_dts = '0;

   pes_header_parser i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   function automatic bit optional_header_follows(input logic [7:0] sid);
      foreach (plain_ids[i]) begin
         if (plain_ids[i] == sid) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic bit stamp_byte_ok(input int idx, input logic [7:0] b,
                                        input logic [3:0] prefix);
      if (idx == 0) return (b[7:4] == prefix) && b[0];
      return (idx == 2 || idx == 4) ? b[0] : 1'b1;
   endfunction

   function automatic logic [32:0] stamp_bits(input int idx, input logic [7:0] b);
      logic [32:0] w;
      w = {25'd0, b};
      case (idx)
         0: return (w & 33'h0E) << 29;
         1: return w << 22;
         2: return (w & 33'hFE) << 14;
         3: return w << 7;
         default: return (w & 33'hFE) >> 1;
      endcase
   endfunction

   function automatic rsp_type header_result(input status_type st, input bit got_hdr,
                                             input bit pts_ok, input bit dts_ok);
      rsp_type r;
      r.status = st;
      r.sid_byte = hp_sid;
      r.packet_length = hp_len;
      r.header_length = got_hdr ? HDR_LEN_OPT + {1'b0, hp_dlen} : HDR_LEN_BASE;
      r.byte6_flags = hp_f6;
      r.byte7_flags = hp_f7;
      r.header_data_length = hp_dlen;
      r.has_pts = pts_ok;
      r.pts_value = pts_ok ? hp_pts : '0;
      r.has_dts = dts_ok;
      r.dts_value = dts_ok ? hp_dts : '0;
      hp_done = 1'b1;
      return r;
   endfunction

   function automatic bit predict_header(input req_type beat, output rsp_type res);
      logic [4:0] at;
      logic [1:0] pd;
      logic [7:0] b;
      int         idx;
      b = beat.in_byte;
      res = '0;
      if (beat.packet_start) begin
         hp_pos = '0;
         hp_start = '0;
         hp_sid = '0;
         hp_len = '0;
         hp_f6 = '0;
         hp_f7 = '0;
         hp_dlen = '0;
         hp_pts = '0;
         hp_dts = '0;
         hp_done = 1'b0;
      end else if (hp_done) begin
         return 1'b0;
      end
      at = hp_pos;
      hp_pos = hp_pos + 5'd1;
      pd = hp_f7[7:6];
      if (at <= POS_START_LAST) begin
         hp_start = {hp_start[15:0], b};
         if (at != POS_START_LAST || hp_start == START_CODE) return 1'b0;
         res = header_result(STATUS_BAD_START, 1'b0, 1'b0, 1'b0);
      end else if (at == POS_STREAM_ID) begin
         hp_sid = b;
         return 1'b0;
      end else if (at == POS_LEN_HI) begin
         hp_len = {b, 8'h00};
         return 1'b0;
      end else if (at == POS_LEN_LO) begin
         hp_len[7:0] = b;
         if (optional_header_follows(hp_sid)) return 1'b0;
         res = header_result(STATUS_OK, 1'b0, 1'b0, 1'b0);
      end else if (at == POS_FLAGS6) begin
         if (b[7:6] == FIXED_BITS) begin
            hp_f6 = b[5:0];
            return 1'b0;
         end
         res = header_result(STATUS_BAD_FIXED, 1'b0, 1'b0, 1'b0);
      end else if (at == POS_FLAGS7) begin
         hp_f7 = b;
         return 1'b0;
      end else if (at == POS_DATA_LEN) begin
         hp_dlen = b;
         if (pd == PD_FORBIDDEN) begin
            res = header_result(STATUS_FORBIDDEN, 1'b1, 1'b0, 1'b0);
         end else if ((pd == PD_PTS_ONLY && b < MIN_DL_PTS) ||
                      (pd == PD_PTS_DTS && b < MIN_DL_PTS_DTS)) begin
            res = header_result(STATUS_SHORT, 1'b1, 1'b0, 1'b0);
         end else if (pd == PD_NONE) begin
            res = header_result(STATUS_OK, 1'b1, 1'b0, 1'b0);
         end else begin
            return 1'b0;
         end
      end else if (at <= POS_PTS_LAST) begin
         idx = at - POS_PTS_FIRST;
         if (!stamp_byte_ok(idx, b, pd == PD_PTS_DTS ? PREFIX_PTS_DTS : PREFIX_PTS)) begin
            res = header_result(STATUS_BAD_TS, 1'b1, 1'b0, 1'b0);
         end else begin
            hp_pts = hp_pts | stamp_bits(idx, b);
            if (at != POS_PTS_LAST || pd != PD_PTS_ONLY) return 1'b0;
            res = header_result(STATUS_OK, 1'b1, 1'b1, 1'b0);
         end
      end else if (at <= POS_DTS_LAST) begin
         idx = at - POS_DTS_FIRST;
         if (!stamp_byte_ok(idx, b, PREFIX_DTS)) begin
            res = header_result(STATUS_BAD_TS, 1'b1, 1'b1, 1'b0);
         end else begin
            hp_dts = hp_dts | stamp_bits(idx, b);
            if (at != POS_DTS_LAST) return 1'b0;
            res = header_result(STATUS_OK, 1'b1, 1'b1, 1'b1);
         end
      end else begin
         hp_done = 1'b1;
         return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void check_field(input string name, input logic [32:0] want,
                                       input logic [32:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         error_count++;
      end
   endfunction

   task automatic add_beat(input logic [7:0] b, input bit start, input bit drain_first);
      pending_beat_type pb;
      pb.beat.in_byte = b;
      pb.beat.packet_start = start;
      pb.drain_first = drain_first;
      tx_beats.push_back(pb);
   endtask

   task automatic send_packet(input bit drain_first);
      foreach (packet_bytes[i]) begin
         add_beat(packet_bytes[i], i == 0, drain_first && i == 0);
         header_beats++;
      end
   endtask

   task automatic push_stamp(input logic [3:0] prefix, input logic [32:0] v);
      packet_bytes.push_back({prefix, v[32:30], 1'b1});
      packet_bytes.push_back(v[29:22]);
      packet_bytes.push_back({v[21:15], 1'b1});
      packet_bytes.push_back(v[14:7]);
      packet_bytes.push_back({v[6:0], 1'b1});
   endtask

   task automatic add_packet(input bit drain_first);
      logic [7:0] sid;
      logic [7:0] dlen;
      logic [7:0] floor_len;
      logic [1:0] flags;
      int         keep;
      int         at;
      case ($urandom_range(0, 9))
         0: sid = plain_ids[$urandom_range(0, 7)];
         1: sid = 8'($urandom);
         default: sid = 8'($urandom_range(8'hC0, 8'hEF));
      endcase
      case ($urandom_range(0, 7))
         0: flags = PD_FORBIDDEN;
         1: flags = PD_NONE;
         2, 3, 4: flags = PD_PTS_ONLY;
         default: flags = PD_PTS_DTS;
      endcase
      packet_bytes.delete();
      packet_bytes.push_back(START_CODE[23:16]);
      packet_bytes.push_back(START_CODE[15:8]);
      packet_bytes.push_back(START_CODE[7:0]);
      packet_bytes.push_back(sid);
      packet_bytes.push_back(8'($urandom));
      packet_bytes.push_back(8'($urandom));
      if (optional_header_follows(sid)) begin
         packet_bytes.push_back({FIXED_BITS, 6'($urandom)});
         packet_bytes.push_back({flags, 6'($urandom)});
         floor_len = (flags == PD_PTS_DTS) ? MIN_DL_PTS_DTS :
                     (flags == PD_PTS_ONLY) ? MIN_DL_PTS : 8'd0;
         case ($urandom_range(0, 9))
            0: dlen = (floor_len == 0) ? 8'd0 : 8'($urandom_range(0, floor_len - 1));
            1: dlen = 8'hFF;
            default: dlen = 8'($urandom_range(floor_len, floor_len + 8));
         endcase
         packet_bytes.push_back(dlen);
         if (flags[1])
            push_stamp(flags == PD_PTS_DTS ? PREFIX_PTS_DTS : PREFIX_PTS,
                       {1'($urandom), 32'($urandom)});
         if (flags == PD_PTS_DTS)
            push_stamp(PREFIX_DTS, {1'($urandom), 32'($urandom)});
      end
      // single bit error somewhere in the header
      if ($urandom_range(0, 4) == 0) begin
         at = $urandom_range(0, packet_bytes.size() - 1);
         packet_bytes[at] = packet_bytes[at] ^ (8'h01 << $urandom_range(0, 7));
      end
      keep = packet_bytes.size();
      if ($urandom_range(0, 9) == 0) keep = $urandom_range(1, packet_bytes.size());
      while (packet_bytes.size() > keep) void'(packet_bytes.pop_back());
      send_packet(drain_first);
      repeat ($urandom_range(0, 2)) add_beat(8'($urandom), 1'b0, 1'b0);
   endtask

   // sender: bursts with gaps, holds at marked beats until all results are back
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
            req_valid <= 1'b0;
         end else if (tx_beats.size() > 0 &&
                      !(tx_beats[0].drain_first && expected_headers.size() > 0)) begin
            req_data <= tx_beats[0].beat;
            req_valid <= 1'b1;
            void'(tx_beats.pop_front());
            burst_left = burst_left - 1;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rx_phase = rx_phase + 1;
      if (rx_phase % 32 == 0) rx_mode = rx_mode_type'($urandom_range(0, 3));
      case (rx_mode)
         RX_OPEN: rsp_ready <= 1'b1;
         RX_COIN: rsp_ready <= 1'($urandom_range(0, 1));
         RX_SPARSE: rsp_ready <= ($urandom_range(0, 7) == 0);
         default: rsp_ready <= ((rx_phase / 16) % 2 == 1);
      endcase
   end

   always @(posedge clock) begin
      if (reset) begin
         req_took = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_headers.size() == 0) begin
               $display("%0t: result beat with nothing pending, actual %h", $time, rsp_data);
               error_count++;
            end else begin
               wanted = expected_headers.pop_front();
               check_field("status", wanted.status, rsp_data.status);
               check_field("sid_byte", wanted.sid_byte, rsp_data.sid_byte);
               check_field("packet_length", wanted.packet_length, rsp_data.packet_length);
               check_field("header_length", wanted.header_length, rsp_data.header_length);
               check_field("byte6_flags", wanted.byte6_flags, rsp_data.byte6_flags);
               check_field("byte7_flags", wanted.byte7_flags, rsp_data.byte7_flags);
               check_field("header_data_length", wanted.header_data_length,
                           rsp_data.header_data_length);
               check_field("has_pts", wanted.has_pts, rsp_data.has_pts);
               check_field("pts_value", wanted.pts_value, rsp_data.pts_value);
               check_field("has_dts", wanted.has_dts, rsp_data.has_dts);
               check_field("dts_value", wanted.dts_value, rsp_data.dts_value);
            end
         end
         req_took = req_valid && req_ready;
         if (req_took && predict_header(req_data, predicted))
            expected_headers.push_back(predicted);
      end
   end

   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      int pkt_no;
      // byte ignored while waiting for a start
      add_beat(8'hFF, 1'b0, 1'b0);
      // start again part way through a header
      packet_bytes = '{8'h00, 8'h00, 8'h01, 8'hE0};
      send_packet(1'b0);
      // full pts and dts, all flag bits set, extreme timestamps and lengths
      packet_bytes = '{8'h00, 8'h00, 8'h01, 8'hC0, 8'h00, 8'h00, 8'hBF, 8'hFF, 8'hFF,
                       8'h3F, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                       8'h11, 8'h00, 8'h01, 8'h00, 8'h01};
      send_packet(1'b0);
      add_beat(8'hA5, 1'b0, 1'b0);
      packet_bytes = '{8'h01, 8'h00, 8'h00};
      send_packet(1'b0);
      packet_bytes = '{8'h00, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'hFF};
      send_packet(1'b0);
      pkt_no = 0;
      while (header_beats < 1050) begin
         if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 4))
               add_beat(8'($urandom), $urandom_range(0, 3) == 0, 1'b0);
         end else begin
            add_packet(pkt_no % 40 == 39);
            pkt_no++;
         end
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (tx_beats.size() > 0 || req_valid) @(negedge clock);
      while (expected_headers.size() > 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
